@@ sv/emi_pkg.sv @@
// Shared types and constants for the eased motion interpolator.
// Used by emi_muldiv and eased_motion_interpolator_top; depends on nothing.
`default_nettype none

package emi_pkg;

  localparam int CoordBitsDef = 16;
  localparam int FracBitsDef  = 8;
  localparam int CoordW       = 16;
  localparam int FrameW       = 20;
  localparam int CountW       = 16;
  localparam int WeightW      = 8;
  localparam int MdW          = 48;
  localparam int SqrtW        = 40;
  localparam int SqrtSteps    = SqrtW / 2;
  localparam int Axes         = 3;

  typedef enum logic [1:0] {
    EASE_LINEAR,
    EASE_WEIGHTED,
    EASE_SYMMETRIC,
    EASE_ACCEL
  } ease_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQRT,
    ST_SDIV,
    ST_PREP_P,
    ST_PREP_Q,
    ST_AXIS,
    ST_OP1,
    ST_OP2
  } emi_state_e;

  typedef struct packed {
    logic                  start;
    logic signed [MdW-1:0] a;
    logic signed [MdW-1:0] b;
    logic        [MdW-1:0] c;
  } md_req_t;

  typedef struct packed {
    logic                  done;
    logic signed [MdW-1:0] q;
  } md_rsp_t;

endpackage

`default_nettype wire

@@ sv/eased_motion_interpolator_top.sv @@
// Eased motion interpolator top level: request handshake, sequencer, axis datapath.
// Depends on emi_pkg and emi_muldiv.
`default_nettype none

// A start request latches start and destination points, easing curve and frame count
// (or a speed, turned into a count by an integer square root and a divide). Each later
// tick request yields the eased position for the next frame; the final frame returns
// the destination with last set, and a tick with the unit absent ends the move silently.
// All multiplies and divides go through one shared multiply-divide unit. A start in frame
// mode needs no operation; in speed mode it takes four operations plus an integer square
// root. A tick costs per axis one operation for the linear curve and two for the others,
// three axes in turn, and the weighted curve adds two operations per tick.
// The block takes no request while busy or while a result waits on the output.

module eased_motion_interpolator_top #(
  parameter int COORD_BITS = emi_pkg::CoordBitsDef,
  parameter int FRAC_BITS  = emi_pkg::FracBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               cmd_i,
  input  logic signed [emi_pkg::CoordW-1:0]  start_x_i,
  input  logic signed [emi_pkg::CoordW-1:0]  start_y_i,
  input  logic signed [emi_pkg::CoordW-1:0]  start_z_i,
  input  logic signed [emi_pkg::CoordW-1:0]  dest_x_i,
  input  logic signed [emi_pkg::CoordW-1:0]  dest_y_i,
  input  logic signed [emi_pkg::CoordW-1:0]  dest_z_i,
  input  logic [1:0]                         easing_i,
  input  logic [emi_pkg::WeightW-1:0]        ease_weight_i,
  input  logic                               speed_mode_i,
  input  logic [emi_pkg::CountW-1:0]         count_or_speed_i,
  input  logic                               unit_present_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [emi_pkg::CoordW-1:0]  out_x_o,
  output logic signed [emi_pkg::CoordW-1:0]  out_y_o,
  output logic signed [emi_pkg::CoordW-1:0]  out_z_o,
  output logic                               last_o
);
  import emi_pkg::*;

  localparam int StepW = $clog2(SqrtSteps);
  localparam logic signed [MdW-1:0] CoordMax = MdW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [MdW-1:0] CoordMin = -CoordMax - MdW'(1);
  localparam logic signed [MdW-1:0] RoundAdd = MdW'((64'sd1 <<< FRAC_BITS) - 64'sd1);
  localparam logic signed [MdW-1:0] MdOne    = MdW'(1);

  function automatic logic signed [CoordW-1:0] sext_c(input logic [CoordW-1:0] v);
    logic signed [CoordW-1:0] t;
    t = signed'(v << (CoordW - COORD_BITS));
    return t >>> (CoordW - COORD_BITS);
  endfunction

  emi_state_e               state_q, state_d;
  logic [1:0]               ax_q, ax_d;
  logic                     issued_q, issued_d;
  logic                     moving_q, moving_d;
  logic signed [CoordW-1:0] start_q [Axes];
  logic signed [CoordW-1:0] start_d [Axes];
  logic signed [CoordW-1:0] end_q [Axes];
  logic signed [CoordW-1:0] end_d [Axes];
  ease_e                    kind_q, kind_d;
  logic [WeightW-1:0]       weight_q, weight_d;
  logic [FrameW-1:0]        total_q, total_d;
  logic [FrameW-1:0]        index_q, index_d;
  logic [CountW-1:0]        count_q, count_d;
  logic [SqrtW-1:0]         sum_q, sum_d;
  logic [SqrtW-1:0]         root_q, root_d;
  logic [SqrtW-1:0]         bit_q, bit_d;
  logic [StepW-1:0]         step_q, step_d;
  logic [FrameW-1:0]        mid_q, mid_d;
  logic [FrameW-1:0]        elap_q, elap_d;
  logic                     late_q, late_d;
  logic signed [MdW-1:0]    p_q, p_d;
  logic signed [MdW-1:0]    pq_q, pq_d;
  logic signed [MdW-1:0]    scaled_q, scaled_d;
  logic signed [MdW-1:0]    r1_q, r1_d;
  logic signed [CoordW-1:0] out_q [Axes];
  logic signed [CoordW-1:0] out_d [Axes];
  logic                     last_q, last_d;
  logic                     out_valid_q, out_valid_d;

  md_req_t                  md_req;
  md_rsp_t                  md_rsp;

  logic signed [CoordW:0]   diff;
  logic signed [CoordW+10:0] sprod;
  logic signed [MdW-1:0]    diff_w, delta, s_w, w2, half;
  logic signed [MdW-1:0]    i_w, t_w, mid_w, e_w;
  logic signed [MdW-1:0]    a1, b1, a2, b2, acc, rsum, eased, pos, clamped;
  logic [MdW-1:0]           c1, c2, sq_sh;
  logic                     late_sym;
  logic [FrameW-1:0]        idx_n;
  logic [SqrtW-1:0]         rb;
  logic                     accept;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE) && !out_valid_q;

  assign diff     = {end_q[ax_q][CoordW-1], end_q[ax_q]} - {start_q[ax_q][CoordW-1], start_q[ax_q]};
  assign diff_w   = MdW'(diff);
  assign delta    = diff_w <<< FRAC_BITS;
  assign s_w      = MdW'(start_q[ax_q]) <<< FRAC_BITS;
  assign sprod    = diff * $signed({1'b0, weight_q, 1'b0});
  assign w2       = (delta <<< 5) - scaled_q;
  assign half     = (delta + signed'(MdW'(delta[MdW-1]))) >>> 1;
  assign i_w      = signed'(MdW'(index_q));
  assign t_w      = signed'(MdW'(total_q));
  assign mid_w    = signed'(MdW'(mid_q));
  assign e_w      = signed'(MdW'(elap_q));
  assign late_sym = (kind_q == EASE_SYMMETRIC) && late_q;
  assign idx_n    = index_q + 1'b1;
  assign rb       = root_q + bit_q;
  assign sq_sh    = md_rsp.q << 4;

  assign a1 = (kind_q == EASE_LINEAR || kind_q == EASE_WEIGHTED) ? delta : scaled_q;
  assign b1 = late_sym ? mid_w - e_w : i_w;
  assign c1 = (kind_q == EASE_SYMMETRIC) ? mid_w : t_w;
  assign a2 = (kind_q == EASE_WEIGHTED) ? scaled_q
            : (late_sym ? scaled_q : '0) + r1_q + w2;
  assign b2 = (kind_q == EASE_WEIGHTED) ? p_q : (late_sym ? e_w : i_w);
  assign c2 = (kind_q == EASE_WEIGHTED) ? pq_q
            : ((kind_q == EASE_ACCEL) ? t_w <<< 5 : mid_w <<< 6);

  assign acc     = (kind_q == EASE_WEIGHTED && state_q == ST_OP2) ? r1_q + md_rsp.q : md_rsp.q;
  assign rsum    = s_w + acc + (late_sym ? half : '0);
  assign eased   = rsum + (rsum[MdW-1] ? RoundAdd : '0);
  assign pos     = eased >>> FRAC_BITS;
  assign clamped = (pos > CoordMax) ? CoordMax : ((pos < CoordMin) ? CoordMin : pos);

  always_comb begin
    md_req.start = 1'b0;
    md_req.a     = '0;
    md_req.b     = MdOne;
    md_req.c     = MdOne;
    unique case (state_q)
      ST_SQ: begin
        md_req.a = diff_w;
        md_req.b = diff_w;
      end
      ST_SDIV: begin
        md_req.a = signed'(MdW'(root_q));
        md_req.c = MdW'(count_q);
      end
      ST_PREP_P: begin
        md_req.a = t_w - i_w;
        md_req.b = i_w;
      end
      ST_PREP_Q: begin
        md_req.a = t_w;
        md_req.b = t_w <<< 5;
      end
      ST_OP1: begin
        md_req.a = a1;
        md_req.b = b1;
        md_req.c = c1;
      end
      ST_OP2: begin
        md_req.a = a2;
        md_req.b = b2;
        md_req.c = c2;
      end
      default: md_req.a = '0;
    endcase
    if (state_q == ST_SQ || state_q == ST_SDIV || state_q == ST_PREP_P ||
        state_q == ST_PREP_Q || state_q == ST_OP1 || state_q == ST_OP2) begin
      md_req.start = !issued_q;
    end
  end

  emi_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  always_comb begin
    state_d     = state_q;
    ax_d        = ax_q;
    issued_d    = issued_q;
    moving_d    = moving_q;
    start_d     = start_q;
    end_d       = end_q;
    kind_d      = kind_q;
    weight_d    = weight_q;
    total_d     = total_q;
    index_d     = index_q;
    count_d     = count_q;
    sum_d       = sum_q;
    root_d      = root_q;
    bit_d       = bit_q;
    step_d      = step_q;
    mid_d       = mid_q;
    elap_d      = elap_q;
    late_d      = late_q;
    p_d         = p_q;
    pq_d        = pq_q;
    scaled_d    = scaled_q;
    r1_d        = r1_q;
    out_d       = out_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (md_req.start) begin
      issued_d = 1'b1;
    end
    if (md_rsp.done) begin
      issued_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i) begin
            start_d[0] = sext_c(start_x_i);
            start_d[1] = sext_c(start_y_i);
            start_d[2] = sext_c(start_z_i);
            end_d[0]   = sext_c(dest_x_i);
            end_d[1]   = sext_c(dest_y_i);
            end_d[2]   = sext_c(dest_z_i);
            kind_d     = ease_e'(easing_i);
            weight_d   = ease_weight_i;
            index_d    = '0;
            count_d    = count_or_speed_i;
            moving_d   = 1'b0;
            if (speed_mode_i && count_or_speed_i != '0) begin
              sum_d   = '0;
              ax_d    = '0;
              state_d = ST_SQ;
            end else begin
              total_d = speed_mode_i ? '0 : FrameW'(count_or_speed_i);
              if (!speed_mode_i && count_or_speed_i > CountW'(1)) begin
                moving_d = 1'b1;
              end else begin
                out_d       = end_d;
                last_d      = 1'b1;
                out_valid_d = 1'b1;
              end
            end
          end else if (moving_q) begin
            if (!unit_present_i) begin
              moving_d = 1'b0;
            end else begin
              index_d = idx_n;
              if ({1'b0, idx_n} + 1'b1 >= {1'b0, total_q}) begin
                moving_d    = 1'b0;
                out_d       = end_q;
                last_d      = 1'b1;
                out_valid_d = 1'b1;
              end else begin
                mid_d   = total_q >> 1;
                late_d  = {idx_n, 1'b0} >= {1'b0, total_q};
                elap_d  = idx_n - (total_q >> 1);
                ax_d    = '0;
                state_d = (kind_q == EASE_WEIGHTED) ? ST_PREP_P : ST_AXIS;
              end
            end
          end
        end
      end
      ST_SQ: begin
        if (md_rsp.done) begin
          sum_d = sum_q + sq_sh[SqrtW-1:0];
          if (ax_q == 2'd2) begin
            root_d  = '0;
            bit_d   = SqrtW'(1) << (SqrtW - 2);
            step_d  = '0;
            state_d = ST_SQRT;
          end else begin
            ax_d = ax_q + 1'b1;
          end
        end
      end
      ST_SQRT: begin
        if (sum_q >= rb) begin
          sum_d  = sum_q - rb;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (step_q == StepW'(SqrtSteps - 1)) begin
          state_d = ST_SDIV;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_SDIV: begin
        if (md_rsp.done) begin
          total_d = md_rsp.q[FrameW-1:0];
          state_d = ST_IDLE;
          if (md_rsp.q[FrameW-1:0] > FrameW'(1)) begin
            moving_d = 1'b1;
          end else begin
            out_d       = end_q;
            last_d      = 1'b1;
            out_valid_d = 1'b1;
          end
        end
      end
      ST_PREP_P: begin
        if (md_rsp.done) begin
          p_d     = md_rsp.q;
          state_d = ST_PREP_Q;
        end
      end
      ST_PREP_Q: begin
        if (md_rsp.done) begin
          pq_d    = md_rsp.q;
          state_d = ST_AXIS;
        end
      end
      ST_AXIS: begin
        scaled_d = MdW'(sprod) <<< FRAC_BITS;
        state_d  = ST_OP1;
      end
      ST_OP1, ST_OP2: begin
        if (md_rsp.done) begin
          r1_d = md_rsp.q;
          if (state_q == ST_OP1 && kind_q != EASE_LINEAR) begin
            state_d = ST_OP2;
          end else begin
            out_d[ax_q] = clamped[CoordW-1:0];
            if (ax_q == 2'd2) begin
              last_d      = 1'b0;
              out_valid_d = 1'b1;
              state_d     = ST_IDLE;
            end else begin
              ax_d    = ax_q + 1'b1;
              state_d = ST_AXIS;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ax_q        <= '0;
      issued_q    <= 1'b0;
      moving_q    <= 1'b0;
      out_valid_q <= 1'b0;
      start_q     <= '{default: '0};
      end_q       <= '{default: '0};
      kind_q      <= EASE_LINEAR;
      weight_q    <= '0;
      total_q     <= '0;
      index_q     <= '0;
    end else begin
      state_q     <= state_d;
      ax_q        <= ax_d;
      issued_q    <= issued_d;
      moving_q    <= moving_d;
      out_valid_q <= out_valid_d;
      start_q     <= start_d;
      end_q       <= end_d;
      kind_q      <= kind_d;
      weight_q    <= weight_d;
      total_q     <= total_d;
      index_q     <= index_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q  <= count_d;
    sum_q    <= sum_d;
    root_q   <= root_d;
    bit_q    <= bit_d;
    step_q   <= step_d;
    mid_q    <= mid_d;
    elap_q   <= elap_d;
    late_q   <= late_d;
    p_q      <= p_d;
    pq_q     <= pq_d;
    scaled_q <= scaled_d;
    r1_q     <= r1_d;
    out_q    <= out_d;
    last_q   <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_q[0];
  assign out_y_o     = out_q[1];
  assign out_z_o     = out_q[2];
  assign last_o      = last_q;

  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !in_ready_o)
    else $error("request accepted while a result waits");

  a_moving_frames: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (moving_q && state_q == ST_IDLE) |->
      (total_q >= FrameW'(2) && {1'b0, index_q} + 1'b1 < {1'b0, total_q}))
    else $error("idle move with no frame left");

  a_md_done_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_rsp.done |-> (issued_q && (state_q == ST_SQ || state_q == ST_SDIV ||
      state_q == ST_PREP_P || state_q == ST_PREP_Q || state_q == ST_OP1 ||
      state_q == ST_OP2)))
    else $error("multiply-divide result with no owner");

endmodule

`default_nettype wire

@@ sv/emi_muldiv.sv @@
// Shared sequential multiply-divide unit: q = (a * b) / c, truncated toward zero.
// Multiplies one 16-bit digit per cycle, then divides one quotient bit per cycle.
// Depends on emi_pkg.
`default_nettype none

module emi_muldiv (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  emi_pkg::md_req_t req_i,
  output emi_pkg::md_rsp_t rsp_o
);
  import emi_pkg::*;

  localparam int DigW   = 16;
  localparam int Digits = MdW / DigW;
  localparam int CntW   = $clog2(MdW);

  md_state_e            state_q, state_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 neg_q, neg_d;
  logic                 done_q, done_d;
  logic [MdW-1:0]       ma_q, ma_d;
  logic [MdW-1:0]       mb_q, mb_d;
  logic [MdW-1:0]       c_q, c_d;
  logic [2*MdW-1:0]     prod_q, prod_d;
  logic [MdW+DigW-1:0]  part;
  logic [MdW:0]         trial;
  logic [MdW:0]         diff;

  assign part  = ma_q * mb_q[MdW-1 -: DigW];
  assign trial = prod_q[2*MdW-1:MdW-1];
  assign diff  = trial - {1'b0, c_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    ma_d    = ma_q;
    mb_d    = mb_q;
    c_d     = c_q;
    prod_d  = prod_q;
    unique case (state_q)
      MD_IDLE: begin
        if (req_i.start) begin
          ma_d    = req_i.a[MdW-1] ? MdW'(-req_i.a) : MdW'(req_i.a);
          mb_d    = req_i.b[MdW-1] ? MdW'(-req_i.b) : MdW'(req_i.b);
          neg_d   = req_i.a[MdW-1] ^ req_i.b[MdW-1];
          c_d     = req_i.c;
          prod_d  = '0;
          cnt_d   = '0;
          state_d = MD_MUL;
        end
      end
      MD_MUL: begin
        prod_d = (prod_q << DigW) + (2*MdW)'(part);
        mb_d   = mb_q << DigW;
        if (cnt_q == CntW'(Digits - 1)) begin
          cnt_d   = '0;
          state_d = MD_DIV;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      MD_DIV: begin
        if (trial >= {1'b0, c_q}) begin
          prod_d = {diff[MdW-1:0], prod_q[MdW-2:0], 1'b1};
        end else begin
          prod_d = {trial[MdW-1:0], prod_q[MdW-2:0], 1'b0};
        end
        if (cnt_q == CntW'(MdW - 1)) begin
          done_d  = 1'b1;
          state_d = MD_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: state_d = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    ma_q   <= ma_d;
    mb_q   <= mb_d;
    c_q    <= c_d;
    prod_q <= prod_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q    = neg_q ? -signed'(prod_q[MdW-1:0]) : signed'(prod_q[MdW-1:0]);

endmodule

`default_nettype wire

@@ tb/tb_eased_motion_interpolator_top.sv @@
// Self-checking testbench for eased_motion_interpolator_top: a queue-fed request driver,
// a result monitor and a built-in easing predictor with exact 128-bit intermediates.
// Depends on emi_pkg and the interpolator RTL only.
`default_nettype none

module tb_eased_motion_interpolator_top;
  import emi_pkg::*;

  localparam bit CMD_TICK  = 1'b0;
  localparam bit CMD_START = 1'b1;
  localparam int unsigned CYCLE_LIMIT = 40_000_000;
  localparam int HOLD_CYCLES = 4000;
  localparam int RAND_ITEMS = 2000;

  typedef struct {
    bit              cmd;
    bit signed [15:0] sx, sy, sz, dx, dy, dz;
    ease_e           easing;
    bit [7:0]        weight;
    bit              speed_mode;
    bit [15:0]       count;
    bit              present;
  } move_req_t;

  typedef struct {
    bit signed [15:0] x, y, z;
    bit               last;
  } position_t;

  logic clk_i, rst_ni;
  logic in_valid, in_ready, out_valid, out_ready;
  logic cmd;
  logic signed [15:0] sx, sy, sz, dx, dy, dz;
  logic [1:0] easing;
  logic [7:0] weight;
  logic speed_mode, present;
  logic [15:0] count;
  logic signed [15:0] ox, oy, oz;
  logic olast;

  eased_motion_interpolator_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .cmd_i(cmd), .start_x_i(sx), .start_y_i(sy), .start_z_i(sz),
    .dest_x_i(dx), .dest_y_i(dy), .dest_z_i(dz),
    .easing_i(easing), .ease_weight_i(weight), .speed_mode_i(speed_mode),
    .count_or_speed_i(count), .unit_present_i(present),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_x_o(ox), .out_y_o(oy), .out_z_o(oz), .last_o(olast)
  );

  move_req_t  pending_q[$];
  position_t  position_q[$];

  // predictor state
  longint     p_start[3], p_end[3];
  ease_e      p_kind;
  longint     p_weight;
  int unsigned p_total, p_index;
  bit         p_moving;

  int unsigned cycles;
  int mismatches, results, finals, starts, ticks, popped;
  int tx_idle, rx_idle, hold_cnt;
  bit held;

  function automatic longint scaled_div(longint a, longint b, longint c);
    logic [127:0] ua, ub, q;
    bit neg;
    if (c <= 0) return 0;
    neg = (a < 0) != (b < 0);
    ua = {64'd0, (a < 0) ? 64'(-a) : 64'(a)};
    ub = {64'd0, (b < 0) ? 64'(-b) : 64'(b)};
    q = (ua * ub) / {64'd0, 64'(c)};
    if (q > 128'h7FFF_FFFF_FFFF_FFFF) q = 128'h7FFF_FFFF_FFFF_FFFF;
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint eased_pos(int ax, longint i);
    longint s, e, delta, total, w, wtd, scl, step, mid, el;
    s = p_start[ax] * 256;
    e = p_end[ax] * 256;
    delta = e - s;
    total = longint'(p_total);
    w = p_weight;
    wtd = delta * (16 - w);
    scl = delta * w * 2;
    case (p_kind)
      EASE_LINEAR: return scaled_div(delta, i, total) + s;
      EASE_WEIGHTED: begin
        step = scaled_div(scl + wtd + wtd, i, total * 32);
        step += scaled_div(scl, (total - i) * i, total * 32 * total);
        return step + s;
      end
      EASE_ACCEL: begin
        step = scaled_div(scl, i, total);
        step = scaled_div(step + wtd + wtd, i, total * 32);
        return step + s;
      end
      default: begin
        mid = total / 2;
        if (mid == 0) mid = 1;
        if (i * 2 < total) begin
          step = scaled_div(scl, i, mid);
          step = scaled_div(step + wtd + wtd, i, mid * 64);
          return step + s;
        end
        el = i - mid;
        step = scaled_div(scl, mid - el, mid);
        step = scaled_div(scl + step + wtd + wtd, el, mid * 64);
        return step + s + delta / 2;
      end
    endcase
  endfunction

  function automatic bit signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic position_t dest_pos();
    position_t p;
    p.x = clamp16(p_end[0]);
    p.y = clamp16(p_end[1]);
    p.z = clamp16(p_end[2]);
    p.last = 1'b1;
    return p;
  endfunction

  task automatic advance_motion(input move_req_t r);
    longint unsigned sum, n;
    longint d;
    position_t p;
    if (r.cmd == CMD_START) begin
      starts++;
      p_start[0] = r.sx; p_start[1] = r.sy; p_start[2] = r.sz;
      p_end[0] = r.dx; p_end[1] = r.dy; p_end[2] = r.dz;
      p_kind = r.easing;
      p_weight = longint'(r.weight);
      n = 64'(r.count);
      if (r.speed_mode) begin
        sum = 0;
        for (int a = 0; a < 3; a++) begin
          d = p_end[a] - p_start[a];
          sum += longint'(d * d) * 16;
        end
        n = (r.count == 0) ? 0 : int_sqrt(sum) / r.count;
      end
      p_total = 32'(n & 64'hFFFFF);
      p_index = 0;
      p_moving = p_total > 1;
      if (!p_moving) position_q.push_back(dest_pos());
      return;
    end
    ticks++;
    if (!p_moving) return;
    if (!r.present) begin
      p_moving = 0;
      return;
    end
    p_index = (p_index + 1) & 32'hFFFFF;
    if (p_index + 1 >= p_total) begin
      p_moving = 0;
      position_q.push_back(dest_pos());
      return;
    end
    p.x = clamp16(eased_pos(0, p_index) / 256);
    p.y = clamp16(eased_pos(1, p_index) / 256);
    p.z = clamp16(eased_pos(2, p_index) / 256);
    p.last = 1'b0;
    position_q.push_back(p);
  endtask

  function automatic move_req_t noise_req();
    move_req_t r;
    r.cmd = 1'($urandom_range(1)); r.sx = 16'($urandom); r.sy = 16'($urandom);
    r.sz = 16'($urandom);
    r.dx = 16'($urandom); r.dy = 16'($urandom); r.dz = 16'($urandom);
    r.easing = ease_e'($urandom_range(3)); r.weight = 8'($urandom);
    r.speed_mode = 1'($urandom_range(1)); r.count = 16'($urandom);
    r.present = 1'($urandom_range(1));
    return r;
  endfunction

  function automatic move_req_t start_req(int x0, int y0, int z0, int x1, int y1, int z1,
                                          ease_e k, int w, bit spd, int n);
    move_req_t r;
    r = noise_req();
    r.cmd = CMD_START;
    r.sx = 16'(x0); r.sy = 16'(y0); r.sz = 16'(z0);
    r.dx = 16'(x1); r.dy = 16'(y1); r.dz = 16'(z1);
    r.easing = k; r.weight = 8'(w); r.speed_mode = spd; r.count = 16'(n);
    return r;
  endfunction

  function automatic move_req_t tick_req(bit here);
    move_req_t r;
    r = noise_req();
    r.cmd = CMD_TICK;
    r.present = here;
    return r;
  endfunction

  task automatic queue_ticks(int n);
    for (int k = 0; k < n; k++) pending_q.push_back(tick_req(1'b1));
  endtask

  task automatic queue_random_move();
    move_req_t r;
    int span;
    r = noise_req();
    r.cmd = CMD_START;
    if ($urandom_range(3) == 0) begin
      span = $urandom_range(200);
      r.dx = 16'(r.sx + $signed($urandom_range(2 * span)) - span);
      r.dy = 16'(r.sy + $signed($urandom_range(2 * span)) - span);
      r.dz = 16'(r.sz + $signed($urandom_range(2 * span)) - span);
    end
    case ($urandom_range(5))
      0: r.weight = 0;
      1: r.weight = 16;
      2: r.weight = 255;
      default: r.weight = 8'($urandom);
    endcase
    if ($urandom_range(3) == 0) begin
      r.speed_mode = 1'b1;
      r.count = ($urandom_range(15) == 0) ? 16'd0 : 16'($urandom_range(65535, 1));
    end else begin
      r.speed_mode = 1'b0;
      r.count = ($urandom_range(40) == 0) ? 16'($urandom) : 16'($urandom_range(20));
    end
    pending_q.push_back(r);
    for (int k = $urandom_range(22); k > 0; k--)
      pending_q.push_back(tick_req($urandom_range(24) != 0));
  endtask

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("eased_motion_interpolator_top verification failed");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 0;
      popped <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) advance_motion('{cmd, sx, sy, sz, dx, dy, dz, ease_e'(easing), weight,
                                     speed_mode, count, present});
      if (pending_q.size() != 0 && $urandom_range(99) >= tx_idle) begin
        move_req_t r;
        r = pending_q.pop_front();
        popped <= popped + 1;
        in_valid <= 1; cmd <= r.cmd;
        sx <= r.sx; sy <= r.sy; sz <= r.sz; dx <= r.dx; dy <= r.dy; dz <= r.dz;
        easing <= r.easing; weight <= r.weight; speed_mode <= r.speed_mode;
        count <= r.count; present <= r.present;
      end else begin
        in_valid <= 0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt <= 0;
      held <= 0;
    end else if (!held && popped >= 300) begin
      hold_cnt <= HOLD_CYCLES;
      held <= 1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_ready <= 0;
    else out_ready <= (hold_cnt == 0) && ($urandom_range(99) >= rx_idle);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      position_t e;
      results++;
      if (olast) finals++;
      if (position_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected position %0d %0d %0d last %0d",
                                       ox, oy, oz, olast);
      end else begin
        e = position_q.pop_front();
        if (e.x !== ox || e.y !== oy || e.z !== oz || e.last !== olast) begin
          mismatches++;
          if (mismatches <= 10)
            $display("position mismatch: expected %0d %0d %0d last %0d, got %0d %0d %0d last %0d",
                     e.x, e.y, e.z, e.last, ox, oy, oz, olast);
        end
      end
    end
  end

  initial begin
    cycles = 0; mismatches = 0; results = 0; finals = 0; starts = 0; ticks = 0;
    tx_idle = 26; rx_idle = 45;
    p_moving = 0; p_total = 0; p_index = 0; p_kind = EASE_LINEAR; p_weight = 0;
    for (int a = 0; a < 3; a++) begin
      p_start[a] = 0;
      p_end[a] = 0;
    end
    in_valid = 0; cmd = 0; sx = 0; sy = 0; sz = 0; dx = 0; dy = 0; dz = 0;
    easing = 0; weight = 0; speed_mode = 0; count = 0; present = 0; out_ready = 0;

    pending_q.push_back(tick_req(1'b1));
    pending_q.push_back(start_req(5, 6, 7, -8, 9, -10, EASE_LINEAR, 0, 0, 0));
    pending_q.push_back(start_req(1, 2, 3, 4, 5, 6, EASE_ACCEL, 16, 0, 1));
    pending_q.push_back(start_req(-32768, 32767, -32768, 32767, -32768, 32767,
                                  EASE_LINEAR, 0, 0, 4));
    queue_ticks(3);
    pending_q.push_back(start_req(-32768, -32768, 0, 32767, 32767, 100,
                                  EASE_WEIGHTED, 255, 0, 5));
    queue_ticks(4);
    pending_q.push_back(start_req(100, -200, 300, -1000, 2000, -3000,
                                  EASE_SYMMETRIC, 255, 0, 7));
    queue_ticks(6);
    pending_q.push_back(start_req(0, 0, 0, 3, 4, 0, EASE_ACCEL, 255, 1, 5));
    queue_ticks(1);
    pending_q.push_back(tick_req(1'b0));
    pending_q.push_back(tick_req(1'b1));
    pending_q.push_back(start_req(0, 0, 0, 50, 50, 50, EASE_SYMMETRIC, 16, 1, 0));
    pending_q.push_back(start_req(10, 10, 10, 20, 20, 20, EASE_WEIGHTED, 16, 0, 65535));
    queue_ticks(2);
    pending_q.push_back(start_req(-5, 5, -5, 5, -5, 5, EASE_SYMMETRIC, 0, 0, 2));
    queue_ticks(1);

    rst_ni = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;

    while (pending_q.size() < RAND_ITEMS) begin
      if ($urandom_range(9) == 0) pending_q.push_back(noise_req());
      else queue_random_move();
    end

    wait (popped >= pending_q.size() / 3 + 25);
    tx_idle = 45; rx_idle = 26;
    wait (pending_q.size() < 700);
    tx_idle = 0; rx_idle = 0;

    while (pending_q.size() != 0 || in_valid || position_q.size() != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);

    $display("covered %0d starts and %0d ticks; %0d positions checked, %0d finishing",
             starts, ticks, results, finals);
    if (mismatches == 0 && position_q.size() == 0) begin
      $display("eased_motion_interpolator_top verification clean");
    end else begin
      $display("%0d mismatches, %0d positions missing", mismatches, position_q.size());
      $display("eased_motion_interpolator_top verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
